@@ design/tbdc_pkg.sv @@
package tbdc_pkg;

   localparam int TIMER_BITS = 16;
   localparam int CFG_BITS = 16;
   localparam int COUNT_BITS = 32;
   localparam int CSR_INDEX_BITS = 8;
   localparam int NUM_TIMERS = 4;

   localparam logic [CSR_INDEX_BITS-1:0] REG_MIN_BREAK = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] REG_BLOCKED = CSR_INDEX_BITS'(1);
   localparam logic [CSR_INDEX_BITS-1:0] REG_TIMEOUT = CSR_INDEX_BITS'(2);
   localparam logic [CSR_INDEX_BITS-1:0] REG_MIN_BETWEEN = CSR_INDEX_BITS'(3);

   localparam logic [CFG_BITS-1:0] MIN_BREAK_RESET = CFG_BITS'(25);
   localparam logic [CFG_BITS-1:0] BLOCKED_RESET = CFG_BITS'(2500);
   localparam logic [CFG_BITS-1:0] TIMEOUT_RESET = CFG_BITS'(500);
   localparam logic [CFG_BITS-1:0] MIN_BETWEEN_RESET = CFG_BITS'(75);

   localparam logic [1:0] TMR_MIN_BREAK = 2'd0;
   localparam logic [1:0] TMR_BLOCKED = 2'd1;
   localparam logic [1:0] TMR_TIMEOUT = 2'd2;
   localparam logic [1:0] TMR_MIN_BETWEEN = 2'd3;

   localparam logic ACT_TICK = 1'b0;
   localparam logic ACT_BEAM = 1'b1;

   localparam logic BEAM_TOP = 1'b0;
   localparam logic BEAM_BOTTOM = 1'b1;

   typedef enum logic [2:0] {
      EV_MIN_BREAK = 3'd0,
      EV_BLOCKED = 3'd1,
      EV_TIMEOUT = 3'd2,
      EV_MIN_BETWEEN = 3'd3,
      EV_BEAM = 3'd4
   } ev_type;

   typedef enum logic [2:0] {
      MODE_IDLE = 3'd0,
      MODE_FIRST_DEB = 3'd1,
      MODE_TRANSIT = 3'd2,
      MODE_WAIT_SECOND = 3'd3,
      MODE_SECOND_DEB = 3'd4,
      MODE_SECOND_VALID = 3'd5,
      MODE_BLOCKED = 3'd6
   } mode_type;

   typedef logic [NUM_TIMERS-1:0][TIMER_BITS-1:0] loads_type;

   typedef struct packed {
      logic action;
      logic beam;
      logic level;
   } req_type;

   typedef struct packed {
      logic signed [COUNT_BITS-1:0] people_count;
      logic count_changed;
      logic buzzer_on;
      logic top_led;
      logic bottom_led;
      logic [2:0] machine_state;
   } rsp_type;

   typedef struct packed {
      mode_type mode;
      logic [1:0] levels;
      logic first_id;
      logic second_id;
      logic [NUM_TIMERS-1:0] running;
      logic [NUM_TIMERS-1:0][TIMER_BITS-1:0] remaining;
      logic [COUNT_BITS-1:0] occupancy;
      logic alarm;
      logic changed;
   } st_type;

endpackage

@@ design/tbdc_cfg.sv @@
module tbdc_cfg (
   input  logic clock,
   input  logic reset,
   input  logic csr_valid,
   input  logic csr_ready,
   input  logic [tbdc_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [tbdc_pkg::CFG_BITS-1:0] csr_data,
   output tbdc_pkg::loads_type loads
);

   localparam int WIDE_BITS = tbdc_pkg::CFG_BITS + tbdc_pkg::TIMER_BITS;

   logic [tbdc_pkg::CFG_BITS-1:0] min_break_ff;
   logic [tbdc_pkg::CFG_BITS-1:0] blocked_ff;
   logic [tbdc_pkg::CFG_BITS-1:0] timeout_ff;
   logic [tbdc_pkg::CFG_BITS-1:0] min_between_ff;

   function automatic logic [tbdc_pkg::TIMER_BITS-1:0] load_value(
      input logic [tbdc_pkg::CFG_BITS-1:0] v
   );
      logic [WIDE_BITS-1:0] wide;
      logic [WIDE_BITS-1:0] limit;
      wide = WIDE_BITS'(v);
      limit = WIDE_BITS'({tbdc_pkg::TIMER_BITS{1'b1}});
      if (wide == '0) begin
         wide = WIDE_BITS'(1);
      end
      if (wide > limit) begin
         wide = limit;
      end
      return tbdc_pkg::TIMER_BITS'(wide);
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         min_break_ff <= tbdc_pkg::MIN_BREAK_RESET;
         blocked_ff <= tbdc_pkg::BLOCKED_RESET;
         timeout_ff <= tbdc_pkg::TIMEOUT_RESET;
         min_between_ff <= tbdc_pkg::MIN_BETWEEN_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            tbdc_pkg::REG_MIN_BREAK: min_break_ff <= csr_data;
            tbdc_pkg::REG_BLOCKED: blocked_ff <= csr_data;
            tbdc_pkg::REG_TIMEOUT: timeout_ff <= csr_data;
            tbdc_pkg::REG_MIN_BETWEEN: min_between_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      loads[tbdc_pkg::TMR_MIN_BREAK] = load_value(min_break_ff);
      loads[tbdc_pkg::TMR_BLOCKED] = load_value(blocked_ff);
      loads[tbdc_pkg::TMR_TIMEOUT] = load_value(timeout_ff);
      loads[tbdc_pkg::TMR_MIN_BETWEEN] = load_value(min_between_ff);
   end

endmodule

@@ design/tbdc_core.sv @@
module tbdc_core (
   input  logic clock,
   input  logic reset,
   input  logic go,
   input  tbdc_pkg::req_type item,
   input  tbdc_pkg::loads_type loads,
   output tbdc_pkg::rsp_type result
);

   tbdc_pkg::st_type st_ff;
   tbdc_pkg::st_type st_in;

   function automatic tbdc_pkg::st_type tmr_start(
      input tbdc_pkg::st_type s,
      input logic [1:0] t,
      input tbdc_pkg::loads_type ld
   );
      tbdc_pkg::st_type n;
      n = s;
      if (!n.running[t]) begin
         n.running[t] = 1'b1;
         n.remaining[t] = ld[t];
      end
      return n;
   endfunction

   function automatic tbdc_pkg::st_type tmr_restart(
      input tbdc_pkg::st_type s,
      input logic [1:0] t,
      input tbdc_pkg::loads_type ld
   );
      tbdc_pkg::st_type n;
      n = s;
      if (n.running[t]) begin
         n.remaining[t] = ld[t];
      end
      return n;
   endfunction

   function automatic tbdc_pkg::st_type tmr_stop(
      input tbdc_pkg::st_type s,
      input logic [1:0] t
   );
      tbdc_pkg::st_type n;
      n = s;
      n.running[t] = 1'b0;
      n.remaining[t] = '0;
      return n;
   endfunction

   function automatic tbdc_pkg::st_type handle_ev(
      input tbdc_pkg::st_type s,
      input tbdc_pkg::ev_type ev,
      input logic beam,
      input logic level,
      input tbdc_pkg::loads_type ld
   );
      tbdc_pkg::st_type n;
      logic is_beam;
      n = s;
      is_beam = (ev == tbdc_pkg::EV_BEAM);
      case (s.mode)
         tbdc_pkg::MODE_IDLE: begin
            if (is_beam && level) begin
               n.mode = tbdc_pkg::MODE_FIRST_DEB;
               n = tmr_start(n, tbdc_pkg::TMR_MIN_BREAK, ld);
               n = tmr_start(n, tbdc_pkg::TMR_BLOCKED, ld);
               n = tmr_start(n, tbdc_pkg::TMR_MIN_BETWEEN, ld);
               n.first_id = beam;
            end
         end
         tbdc_pkg::MODE_FIRST_DEB: begin
            if (ev == tbdc_pkg::EV_MIN_BREAK) begin
               n.mode = tbdc_pkg::MODE_TRANSIT;
            end else begin
               n.mode = tbdc_pkg::MODE_IDLE;
               n = tmr_stop(n, tbdc_pkg::TMR_MIN_BREAK);
               n = tmr_stop(n, tbdc_pkg::TMR_BLOCKED);
               n = tmr_stop(n, tbdc_pkg::TMR_MIN_BETWEEN);
            end
         end
         tbdc_pkg::MODE_TRANSIT: begin
            if (ev == tbdc_pkg::EV_MIN_BETWEEN) begin
               n.mode = tbdc_pkg::MODE_WAIT_SECOND;
            end else begin
               n.mode = tbdc_pkg::MODE_IDLE;
               n = tmr_stop(n, tbdc_pkg::TMR_BLOCKED);
               n = tmr_stop(n, tbdc_pkg::TMR_MIN_BETWEEN);
            end
         end
         tbdc_pkg::MODE_WAIT_SECOND: begin
            if (is_beam && beam != s.first_id && level) begin
               n.mode = tbdc_pkg::MODE_SECOND_DEB;
               n.second_id = beam;
               n = tmr_start(n, tbdc_pkg::TMR_MIN_BREAK, ld);
               // Restart when running and start when stopped both reload it.
               n.running[tbdc_pkg::TMR_BLOCKED] = 1'b1;
               n.remaining[tbdc_pkg::TMR_BLOCKED] = ld[tbdc_pkg::TMR_BLOCKED];
               n = tmr_stop(n, tbdc_pkg::TMR_TIMEOUT);
            end else if (is_beam && beam == s.first_id && !level) begin
               n = tmr_stop(n, tbdc_pkg::TMR_BLOCKED);
               n = tmr_start(n, tbdc_pkg::TMR_TIMEOUT, ld);
            end else if (is_beam && beam == s.first_id && level) begin
               n = tmr_start(n, tbdc_pkg::TMR_BLOCKED, ld);
               n = tmr_stop(n, tbdc_pkg::TMR_TIMEOUT);
            end else if (ev == tbdc_pkg::EV_TIMEOUT) begin
               n.mode = tbdc_pkg::MODE_IDLE;
            end else if (ev == tbdc_pkg::EV_BLOCKED) begin
               n.mode = tbdc_pkg::MODE_BLOCKED;
               n.alarm = 1'b1;
            end
         end
         tbdc_pkg::MODE_SECOND_DEB: begin
            if (ev == tbdc_pkg::EV_MIN_BREAK) begin
               n.mode = tbdc_pkg::MODE_SECOND_VALID;
            end else begin
               if (s.levels[s.first_id]) begin
                  n.mode = tbdc_pkg::MODE_WAIT_SECOND;
                  n = tmr_restart(n, tbdc_pkg::TMR_BLOCKED, ld);
               end else begin
                  n.mode = tbdc_pkg::MODE_IDLE;
                  n = tmr_stop(n, tbdc_pkg::TMR_BLOCKED);
               end
               n = tmr_stop(n, tbdc_pkg::TMR_MIN_BREAK);
            end
         end
         tbdc_pkg::MODE_SECOND_VALID: begin
            if (is_beam && beam == s.second_id && !level && !s.levels[s.first_id]) begin
               n.mode = tbdc_pkg::MODE_IDLE;
               n = tmr_stop(n, tbdc_pkg::TMR_BLOCKED);
               if (s.first_id == tbdc_pkg::BEAM_TOP && s.second_id == tbdc_pkg::BEAM_BOTTOM)
                  begin
                  n.occupancy = s.occupancy + tbdc_pkg::COUNT_BITS'(1);
               end else begin
                  n.occupancy = s.occupancy - tbdc_pkg::COUNT_BITS'(1);
               end
               n.changed = 1'b1;
            end else if (is_beam && beam == s.second_id && !level) begin
               n.mode = tbdc_pkg::MODE_WAIT_SECOND;
               n = tmr_restart(n, tbdc_pkg::TMR_BLOCKED, ld);
            end else if (ev == tbdc_pkg::EV_BLOCKED) begin
               n.mode = tbdc_pkg::MODE_BLOCKED;
               n.alarm = 1'b1;
            end
         end
         tbdc_pkg::MODE_BLOCKED: begin
            if (s.levels == 2'b00) begin
               n.alarm = 1'b0;
               n.mode = tbdc_pkg::MODE_IDLE;
            end
         end
         default: begin
            n = s;
         end
      endcase
      return n;
   endfunction

   always_comb begin
      tbdc_pkg::st_type s;
      logic [tbdc_pkg::NUM_TIMERS-1:0] fired;
      s = st_ff;
      s.changed = 1'b0;
      fired = '0;
      if (item.action == tbdc_pkg::ACT_TICK) begin
         for (int t = 0; t < tbdc_pkg::NUM_TIMERS; t++) begin
            if (s.running[t]) begin
               if (s.remaining[t] != '0) begin
                  s.remaining[t] = s.remaining[t] - tbdc_pkg::TIMER_BITS'(1);
               end
               if (s.remaining[t] == '0) begin
                  s.running[t] = 1'b0;
                  fired[t] = 1'b1;
               end
            end
         end
         // Expiries of one tick are handled in fixed priority order.
         if (fired[tbdc_pkg::TMR_MIN_BREAK]) begin
            s = handle_ev(s, tbdc_pkg::EV_MIN_BREAK, 1'b0, 1'b0, loads);
         end
         if (fired[tbdc_pkg::TMR_BLOCKED]) begin
            s = handle_ev(s, tbdc_pkg::EV_BLOCKED, 1'b0, 1'b0, loads);
         end
         if (fired[tbdc_pkg::TMR_TIMEOUT]) begin
            s = handle_ev(s, tbdc_pkg::EV_TIMEOUT, 1'b0, 1'b0, loads);
         end
         if (fired[tbdc_pkg::TMR_MIN_BETWEEN]) begin
            s = handle_ev(s, tbdc_pkg::EV_MIN_BETWEEN, 1'b0, 1'b0, loads);
         end
      end else begin
         s.levels[item.beam] = item.level;
         s = handle_ev(s, tbdc_pkg::EV_BEAM, item.beam, item.level, loads);
      end
      st_in = s;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= '0;
      end else if (go) begin
         st_ff <= st_in;
      end
   end

   always_comb begin
      result.people_count = signed'(st_in.occupancy);
      result.count_changed = st_in.changed;
      result.buzzer_on = st_in.alarm;
      result.top_led = st_in.levels[tbdc_pkg::BEAM_TOP];
      result.bottom_led = st_in.levels[tbdc_pkg::BEAM_BOTTOM];
      result.machine_state = 3'(st_in.mode);
   end

endmodule

@@ design/two_beam_direction_counter.sv @@
// Channel   Direction  Handshake               Payload
// req_      in         req_valid / req_stall   tbdc_pkg::req_type
// rsp_      out        rsp_valid / rsp_stall   tbdc_pkg::rsp_type
// csr_      in         csr_valid / csr_ready   csr_index, csr_data
//
// An accepted item is held in the input register and is processed when the output
// register can take it, and its result is written there; one item per cycle
// while the result is not stalled. Result valid is driven from the output register.
// Synchronous reset returns the machine to idle and the config registers to their defaults.
// A stalled result holds the output register and, once the input register is
// full, stalls the input channel.
module two_beam_direction_counter (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  tbdc_pkg::req_type req_data,
   output logic rsp_valid,
   input  logic rsp_stall,
   output tbdc_pkg::rsp_type rsp_data,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [tbdc_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [tbdc_pkg::CFG_BITS-1:0] csr_data
);

   logic in_valid_ff;
   tbdc_pkg::req_type in_data_ff;
   logic out_valid_ff;
   tbdc_pkg::rsp_type out_data_ff;
   logic advance;
   logic go;
   tbdc_pkg::loads_type loads;
   tbdc_pkg::rsp_type result;

   assign advance = !out_valid_ff || !rsp_stall;
   assign go = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;
   assign csr_ready = 1'b1;
   assign rsp_valid = out_valid_ff;
   assign rsp_data = out_data_ff;

   tbdc_cfg u_cfg (
      .clock(clock),
      .reset(reset),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data),
      .loads(loads)
   );

   tbdc_core u_core (
      .clock(clock),
      .reset(reset),
      .go(go),
      .item(in_data_ff),
      .loads(loads),
      .result(result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (!req_stall) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            out_valid_ff <= go;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_data_ff <= req_data;
      end
      if (go) begin
         out_data_ff <= result;
      end
   end

endmodule
